FILE: src/pabe_pkg.sv
// Shared constants and types for the packet audio block expander.
// No dependencies; imported by the decoder, the top level and the testbench.
`default_nettype none

package pabe_pkg;

   // stream phase codes
   localparam logic [2:0] PH_LEN_HI = 3'd0;
   localparam logic [2:0] PH_LEN_LO = 3'd1;
   localparam logic [2:0] PH_SHIFTS = 3'd2;
   localparam logic [2:0] PH_CODE   = 3'd3;
   localparam logic [2:0] PH_RAW_HI = 3'd4;
   localparam logic [2:0] PH_RAW_LO = 3'd5;
   localparam logic [2:0] PH_SKIP   = 3'd6;

   localparam logic [7:0]  ESCAPE_CODE = 8'h80;
   localparam logic [10:0] PAIRS       = 11'd1024;

   typedef struct packed {
      logic [2:0]  phase;
      logic [15:0] length;
      logic [16:0] position;
      logic [3:0]  left_shift;
      logic [3:0]  right_shift;
      logic [10:0] pair_count;
      logic        channel;
      logic [7:0]  raw_high;
   } pabe_state_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               channel;
      logic               last_in_packet;
   } pabe_result_type;

endpackage

`default_nettype wire

FILE: src/pabe_channels.sv
// Valid/ready channel interfaces for the byte input and the sample output.
// Depends on nothing but the widths fixed in the block's field list.
`default_nettype none

interface pabe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;

   modport source (output valid, output payload_byte, input ready);
   modport sink   (input valid, input payload_byte, output ready);
endinterface

interface pabe_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;
   logic               channel;
   logic               last_in_packet;

   modport source (output valid, output sample, output channel, output last_in_packet,
                   input ready);
   modport sink   (input valid, input sample, input channel, input last_in_packet,
                   output ready);
endinterface

`default_nettype wire

FILE: src/packet_audio_block_expander_core.sv
// Packet audio block expander, top level: stream state and output register.
// A sample is registered and appears on rsp in the cycle after the transfer of the byte that completes it.
// Throughput: one payload byte per cycle; the output register frees itself in the same
// cycle it is taken, so input stalls only while rsp holds an untaken sample.
// Reset (synchronous, active high) expects a length high byte and empties the output register.
// Depends on pabe_pkg, pabe_channels and pabe_decode.
`default_nettype none

module packet_audio_block_expander_core (
   input  wire logic   clock,
   input  wire logic   reset,
   pabe_req_if.sink    req_chan,
   pabe_rsp_if.source  rsp_chan
);
   import pabe_pkg::*;

   pabe_state_type  state_ff, state_in;
   pabe_state_type  dec_state;
   pabe_result_type dec_result;
   pabe_result_type result_ff, result_in;
   logic            dec_emit;
   logic            valid_ff, valid_in;
   logic            take;

   pabe_decode u_decode (
      .state      (state_ff),
      .byte_in    (req_chan.payload_byte),
      .next_state (dec_state),
      .emit       (dec_emit),
      .result     (dec_result)
   );

   assign req_chan.ready = !valid_ff || rsp_chan.ready;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in  = take ? dec_state : state_ff;
      result_in = result_ff;
      valid_in  = valid_ff && !rsp_chan.ready;
      if (take && dec_emit) begin
         result_in = dec_result;
         valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.sample         = result_ff.sample;
   assign rsp_chan.channel        = result_ff.channel;
   assign rsp_chan.last_in_packet = result_ff.last_in_packet;

endmodule

`default_nettype wire

FILE: src/pabe_decode.sv
// Per-byte decode: next stream state and the optional sample for one payload byte.
// Depends on pabe_pkg.
`default_nettype none

module pabe_decode (
   input  wire pabe_pkg::pabe_state_type  state,
   input  wire logic [7:0]                byte_in,
   output pabe_pkg::pabe_state_type       next_state,
   output logic                           emit,
   output pabe_pkg::pabe_result_type      result
);
   import pabe_pkg::*;

   logic [15:0] ext;
   logic [3:0]  shamt;
   logic [15:0] value;
   logic [10:0] pair_next;
   logic        last;
   logic [16:0] pos_next;

   always_comb begin
      ext       = {{8{byte_in[7]}}, byte_in};
      shamt     = state.channel ? state.right_shift : state.left_shift;
      pair_next = state.pair_count + 11'd1;
      pos_next  = state.position + 17'd1;

      next_state = state;
      emit       = 1'b0;
      value      = ext << shamt;
      last       = 1'b0;

      unique case (state.phase)
         PH_LEN_LO: begin
            next_state.length   = {state.length[15:8], byte_in};
            next_state.position = '0;
            next_state.phase    = ({state.length[15:8], byte_in} == 16'd0) ? PH_LEN_HI
                                                                          : PH_SHIFTS;
         end
         PH_SHIFTS, PH_CODE, PH_RAW_HI, PH_RAW_LO, PH_SKIP: begin
            unique case (state.phase)
               PH_SHIFTS: begin
                  next_state.right_shift = byte_in[3:0];
                  next_state.left_shift  = byte_in[7:4];
                  next_state.pair_count  = '0;
                  next_state.channel     = 1'b0;
                  next_state.phase       = PH_CODE;
               end
               PH_CODE: begin
                  if (byte_in == ESCAPE_CODE) begin
                     next_state.phase = PH_RAW_HI;
                  end else begin
                     emit = 1'b1;
                  end
               end
               PH_RAW_HI: begin
                  next_state.raw_high = byte_in;
                  next_state.phase    = PH_RAW_LO;
               end
               PH_RAW_LO: begin
                  value = {state.raw_high, byte_in};
                  emit  = 1'b1;
               end
               default: begin
               end
            endcase

            if (emit) begin
               if (state.channel) begin
                  next_state.pair_count = pair_next;
                  last                  = (pair_next == PAIRS);
               end
               next_state.channel = ~state.channel;
               next_state.phase   = last ? PH_SKIP : PH_CODE;
            end

            // end of packet takes priority over whatever phase the byte chose
            if (pos_next >= {1'b0, state.length}) begin
               next_state.phase    = PH_LEN_HI;
               next_state.position = '0;
            end else begin
               next_state.position = pos_next;
            end
         end
         default: begin
            // length high byte, and the unused code
            next_state.length   = {byte_in, 8'h00};
            next_state.position = '0;
            next_state.phase    = PH_LEN_LO;
         end
      endcase

      result.sample         = value;
      result.channel        = state.channel;
      result.last_in_packet = last;
   end

endmodule

`default_nettype wire

FILE: tb/pabe_sample_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the packet audio block expander: watches both channels.
// Predicts samples from the input byte stream and compares them. Depends on pabe_pkg, pabe_channels.

module pabe_sample_checker (
   input  logic clock,
   input  logic reset,
   pabe_req_if  req_mon,
   pabe_rsp_if  rsp_mon,
   output int   failures,
   output int   outstanding
);
   import pabe_pkg::*;

   logic [2:0]  phase;
   logic [15:0] length;
   logic [16:0] position;
   logic [3:0]  left_shift;
   logic [3:0]  right_shift;
   logic [10:0] pairs_done;
   logic        chan;
   logic [7:0]  raw_high;

   pabe_result_type expected_samples[$];

   initial failures = 0;

   function automatic void clear_stream();
      phase       = PH_LEN_HI;
      length      = '0;
      position    = '0;
      left_shift  = '0;
      right_shift = '0;
      pairs_done  = '0;
      chan        = 1'b0;
      raw_high    = '0;
   endfunction

   function automatic void push_sample(input logic [15:0] value);
      pabe_result_type r;
      logic            last;
      last = 1'b0;
      r.sample  = value;
      r.channel = chan;
      if (chan) begin
         pairs_done = pairs_done + 11'd1;
         last = (pairs_done == PAIRS);
      end
      r.last_in_packet = last;
      expected_samples.push_back(r);
      chan  = ~chan;
      phase = last ? PH_SKIP : PH_CODE;
   endfunction

   function automatic void expand_byte(input logic [7:0] b);
      logic [15:0] ext;
      logic [3:0]  sh;
      if (phase == PH_LEN_LO) begin
         length   = {length[15:8], b};
         position = '0;
         phase    = (length == 16'd0) ? PH_LEN_HI : PH_SHIFTS;
      end else if (phase < PH_SHIFTS || phase > PH_SKIP) begin
         length   = {b, 8'h00};
         position = '0;
         phase    = PH_LEN_LO;
      end else begin
         case (phase)
            PH_SHIFTS: begin
               right_shift = b[3:0];
               left_shift  = b[7:4];
               pairs_done  = '0;
               chan        = 1'b0;
               phase       = PH_CODE;
            end
            PH_CODE: begin
               if (b == ESCAPE_CODE) begin
                  phase = PH_RAW_HI;
               end else begin
                  ext = {{8{b[7]}}, b};
                  sh  = chan ? right_shift : left_shift;
                  push_sample(ext << sh);
               end
            end
            PH_RAW_HI: begin
               raw_high = b;
               phase    = PH_RAW_LO;
            end
            PH_RAW_LO: begin
               push_sample({raw_high, b});
            end
            default: begin
            end
         endcase
         position = position + 17'd1;
         if (position >= {1'b0, length}) begin
            phase    = PH_LEN_HI;
            position = '0;
         end
      end
   endfunction

   function automatic void check_sample();
      pabe_result_type want;
      bit              bad;
      bad = 1'b0;
      if (expected_samples.size() == 0) begin
         $display("%0t: unexpected sample transfer: sample %h channel %0d last %0d",
                  $time, rsp_mon.sample, rsp_mon.channel, rsp_mon.last_in_packet);
         failures++;
      end else begin
         want = expected_samples.pop_front();
         if (rsp_mon.sample !== want.sample) begin
            $display("%0t: sample mismatch: expected %h actual %h",
                     $time, want.sample, rsp_mon.sample);
            bad = 1'b1;
         end
         if (rsp_mon.channel !== want.channel) begin
            $display("%0t: channel mismatch: expected %0d actual %0d",
                     $time, want.channel, rsp_mon.channel);
            bad = 1'b1;
         end
         if (rsp_mon.last_in_packet !== want.last_in_packet) begin
            $display("%0t: last_in_packet mismatch: expected %0d actual %0d",
                     $time, want.last_in_packet, rsp_mon.last_in_packet);
            bad = 1'b1;
         end
         if (bad) failures++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_stream();
         expected_samples.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) expand_byte(req_mon.payload_byte);
         if (rsp_mon.valid && rsp_mon.ready) check_sample();
      end
      outstanding <= expected_samples.size();
   end

endmodule

FILE: tb/packet_audio_block_expander_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for packet_audio_block_expander_core: clock, reset, byte stimulus, output stalls.
// Depends on pabe_pkg, pabe_channels, the block and pabe_sample_checker.

module packet_audio_block_expander_core_tb;
   import pabe_pkg::*;

   logic clock = 1'b0;
   logic reset;
   int   failures;
   int   outstanding;

   pabe_req_if req_chan ();
   pabe_rsp_if rsp_chan ();

   // framing as the stream sees it, so that noise never leaves it stranded in a huge packet
   int unsigned frame_stage;
   logic [7:0]  frame_len_hi;
   int unsigned frame_left;
   bit          burst_mode;
   int unsigned bytes_sent;

   always #4 clock = ~clock;

   packet_audio_block_expander_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   pabe_sample_checker scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .failures    (failures),
      .outstanding (outstanding)
   );

   function automatic int unsigned idle_cycles();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      gap = burst_mode ? 0 : idle_cycles();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.payload_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      bytes_sent++;
      case (frame_stage)
         0: begin
            frame_len_hi = b;
            frame_stage  = 1;
         end
         1: begin
            frame_left  = 32'({frame_len_hi, b});
            frame_stage = (frame_left == 0) ? 0 : 2;
         end
         default: begin
            frame_left--;
            if (frame_left == 0) frame_stage = 0;
         end
      endcase
   endtask

   // header, shift byte, then codes with a share of escapes; cut-off escapes fall out naturally
   task automatic send_packet(input logic [15:0] len);
      int unsigned left;
      logic [7:0]  code;
      left = 32'(len);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      if (left != 0) begin
         send_byte(8'($urandom_range(0, 255)));
         left--;
      end
      while (left != 0) begin
         code = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 9) == 0) code = ESCAPE_CODE;
         send_byte(code);
         left--;
         if (code == ESCAPE_CODE) begin
            repeat (2) begin
               if (left != 0) begin
                  send_byte(8'($urandom_range(0, 255)));
                  left--;
               end
            end
         end
      end
   endtask

   // output stalls: short runs and stalls, with occasional long stretches of either
   initial begin
      int unsigned run;
      int unsigned stall;
      rsp_chan.ready <= 1'b0;
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
         rsp_chan.ready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = idle_cycles();
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   initial begin
      #20_000_000;
      $display("packet_audio_block_expander_core verification failed");
      $finish;
   end

   initial begin
      logic [7:0]  directed_bytes[] = '{
         8'h00, 8'h00,                                    // zero length
         8'h00, 8'h01, 8'hA5,                             // shift byte only
         8'h00, 8'h0D, 8'hF0, 8'h7F, 8'h81, 8'hFF, 8'h00, // shift extremes
         8'h80, 8'h7F, 8'hFF, 8'h80, 8'h80, 8'h00,        // raw extremes
         8'h01, 8'h80,                                    // escape cut by the end
         8'h00, 8'h03, 8'h0F, 8'h80, 8'h12                // cut after the raw high byte
      };
      int unsigned pick;
      int unsigned len;

      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.payload_byte <= 8'h00;
      frame_stage  = 0;
      frame_len_hi = 8'h00;
      frame_left   = 0;
      burst_mode   = 1'b0;
      bytes_sent   = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

      while (bytes_sent < 1650) begin
         burst_mode = ($urandom_range(0, 4) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            // broken framing, then fill out whatever packet it opened
            repeat ($urandom_range(1, 6)) begin
               if (frame_stage == 0) send_byte(8'($urandom_range(0, 3)));
               else send_byte(8'($urandom_range(0, 255)));
            end
            while (frame_stage != 0) begin
               if (frame_stage == 1) send_byte(8'($urandom_range(0, 63)));
               else send_byte(8'($urandom_range(0, 255)));
            end
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 5) len = 0;
            else if (pick < 75) len = $urandom_range(1, 40);
            else if (pick < 95) len = $urandom_range(41, 200);
            else len = $urandom_range(201, 700);
            send_packet(16'(len));
         end
      end
      burst_mode = 1'b0;
      req_chan.valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("packet_audio_block_expander_core verification clean");
      end else begin
         $display("packet_audio_block_expander_core verification failed");
      end
      $finish;
   end

endmodule
